### rtl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared widths, codes and types of the compacting pool allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int PoolBytesDef  = 4096;
  localparam int MaxRecordsDef = 16;

  localparam int OP_W     = 1;
  localparam int SIZE_W   = 13;
  localparam int OFFSET_W = 12;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BYTES   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cpa_mem_ctl_t;

endpackage

### rtl/cpa_if.sv
// ----------------------------------------------------------------------------
// cpa_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface cpa_req_if import cpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SIZE_W-1:0]   alloc_size;
  logic [OFFSET_W-1:0] free_offset;

  modport source (output valid, operation, alloc_size, free_offset, input ready);
  modport sink (input valid, operation, alloc_size, free_offset, output ready);
endinterface

interface cpa_rsp_if import cpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink (input valid, status, granted_offset, output ready);
endinterface

### rtl/compacting_pool_allocator.sv
// Steps: accept and dispatch; a rejected or zero-size allocate goes straight to
// the result word; a placed allocate may pack the table, checks the fit, may pack
// the pool and places; a free searches the table; then the result word is offered.
// Packs and the free search make one record table read per cycle through the
// single read port; one item at a time, and an unaccepted result word holds off
// the next.
// Reset: asynchronous; table empty, cursor and end offset 0, all bytes free.
// ----------------------------------------------------------------------------
// compacting_pool_allocator
// Bump allocator bookkeeping with a compacting record table.
// ----------------------------------------------------------------------------
module compacting_pool_allocator import cpa_pkg::*; #(
  parameter int POOL_BYTES  = PoolBytesDef,
  parameter int MAX_RECORDS = MaxRecordsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpa_req_if.sink   req_i,
  cpa_rsp_if.source rsp_o
);

  localparam int IDX_W  = $clog2(MAX_RECORDS);
  localparam int DATA_W = $clog2(POOL_BYTES) + SIZE_W;

  cpa_mem_ctl_t      mem_ctl;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  cpa_ctrl #(
    .POOL_BYTES  (POOL_BYTES),
    .MAX_RECORDS (MAX_RECORDS),
    .IDX_W       (IDX_W),
    .DATA_W      (DATA_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cpa_rec_mem #(
    .DEPTH  (MAX_RECORDS),
    .IDX_W  (IDX_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### rtl/cpa_rec_mem.sv
// ----------------------------------------------------------------------------
// cpa_rec_mem
// Record table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpa_rec_mem import cpa_pkg::*; #(
  parameter int DEPTH  = MaxRecordsDef,
  parameter int IDX_W  = $clog2(MaxRecordsDef),
  parameter int DATA_W = $clog2(PoolBytesDef) + SIZE_W
) (
  input  logic              clk_i,
  input  cpa_mem_ctl_t      ctl_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer: dispatch, table pack, pool pack, place, free search, result word.
// ----------------------------------------------------------------------------
module cpa_ctrl import cpa_pkg::*; #(
  parameter int POOL_BYTES  = PoolBytesDef,
  parameter int MAX_RECORDS = MaxRecordsDef,
  parameter int IDX_W       = $clog2(MaxRecordsDef),
  parameter int DATA_W      = $clog2(PoolBytesDef) + SIZE_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cpa_req_if.sink           req_i,
  cpa_rsp_if.source         rsp_o,
  output cpa_mem_ctl_t      mem_ctl_o,
  output logic [IDX_W-1:0]  mem_waddr_o,
  output logic [DATA_W-1:0] mem_wdata_o,
  output logic [IDX_W-1:0]  mem_raddr_o,
  input  logic [DATA_W-1:0] mem_rdata_i
);

  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int ADDR_W = $clog2(POOL_BYTES);
  localparam int BR_W   = $clog2(POOL_BYTES + 1);
  localparam int CMP_W  = (ADDR_W > OFFSET_W) ? ADDR_W : OFFSET_W;
  localparam int SUM_W  = ((BR_W > SIZE_W) ? BR_W : SIZE_W) + 1;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_PTAB     = 3'd2;
  localparam logic [2:0] S_FIT      = 3'd3;
  localparam logic [2:0] S_PPOOL    = 3'd4;
  localparam logic [2:0] S_PLACE    = 3'd5;
  localparam logic [2:0] S_FREE     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [SIZE_W-1:0]     size_q, size_d;
  logic [OFFSET_W-1:0]   off_q, off_d;
  logic [MAX_RECORDS-1:0] live_q, live_d;
  logic [CNT_W-1:0]      live_cnt_q, live_cnt_d;
  logic [CNT_W-1:0]      cursor_q, cursor_d;
  logic [BR_W-1:0]       br_q, br_d;
  logic [BR_W-1:0]       end_q, end_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic [CNT_W-1:0]      dst_q, dst_d;
  logic [BR_W-1:0]       at_q, at_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]      rd_dst_q, rd_dst_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [OFFSET_W-1:0]   res_grant_q, res_grant_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [OFFSET_W-1:0]   out_grant_q, out_grant_d;

  logic [IDX_W-1:0]  scan_idx;
  logic              scan_live;
  logic              scan_end;
  logic              scanning;
  logic [ADDR_W-1:0] rd_start;
  logic [SIZE_W-1:0] rd_len;

  assign scan_idx  = scan_q[IDX_W-1:0];
  assign scan_end  = (scan_q == CNT_W'(MAX_RECORDS));
  assign scan_live = !scan_end && live_q[scan_idx];
  assign scanning  = (state_q == S_PTAB) || (state_q == S_PPOOL) || (state_q == S_FREE);
  assign rd_start  = mem_rdata_i[DATA_W-1 -: ADDR_W];
  assign rd_len    = mem_rdata_i[SIZE_W-1:0];

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.granted_offset = out_grant_q;

  // reads and writes of one pass never meet on an entry: writes trail the scan
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    size_d       = size_q;
    off_d        = off_q;
    live_d       = live_q;
    live_cnt_d   = live_cnt_q;
    cursor_d     = cursor_q;
    br_d         = br_q;
    end_d        = end_q;
    scan_d       = scan_q;
    dst_d        = dst_q;
    at_d         = at_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    rd_dst_d     = rd_dst_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_grant_d  = out_grant_q;
    mem_ctl_o    = '0;
    mem_waddr_o  = '0;
    mem_wdata_o  = '0;
    mem_raddr_o  = scan_idx;

    if (scanning) begin
      if (scan_live) begin
        mem_ctl_o.rd_en = 1'b1;
        rd_vld_d        = 1'b1;
        rd_idx_d        = scan_idx;
      end
      if (!scan_end) begin
        scan_d = scan_q + 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.operation;
          size_d  = req_i.alloc_size;
          off_d   = req_i.free_offset;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_grant_d = '0;
        scan_d      = '0;
        dst_d       = '0;
        if (op_q == OP_FREE) begin
          state_d = S_FREE;
        end else if (SUM_W'(size_q) > SUM_W'(br_q)) begin
          res_status_d = ST_NO_BYTES;
          state_d      = S_DONE;
        end else if (live_cnt_q >= CNT_W'(MAX_RECORDS)) begin
          res_status_d = ST_TABLE_FULL;
          state_d      = S_DONE;
        end else if (size_q == '0) begin
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end else if (cursor_q >= CNT_W'(MAX_RECORDS)) begin
          state_d = S_PTAB;
        end else begin
          state_d = S_FIT;
        end
      end
      S_PTAB: begin
        if (rd_vld_q && (rd_idx_q != rd_dst_q)) begin
          mem_ctl_o.wr_en  = 1'b1;
          mem_waddr_o      = rd_dst_q;
          mem_wdata_o      = mem_rdata_i;
          live_d[rd_dst_q] = 1'b1;
          live_d[rd_idx_q] = 1'b0;
        end
        if (scan_live) begin
          rd_dst_d = dst_q[IDX_W-1:0];
          dst_d    = dst_q + 1'b1;
        end
        if (scan_end && !rd_vld_q) begin
          cursor_d = dst_q;
          state_d  = S_FIT;
        end
      end
      S_FIT: begin
        if (SUM_W'(end_q) + SUM_W'(size_q) > SUM_W'(POOL_BYTES)) begin
          scan_d  = '0;
          at_d    = '0;
          state_d = S_PPOOL;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PPOOL: begin
        if (rd_vld_q) begin
          mem_ctl_o.wr_en = 1'b1;
          mem_waddr_o     = rd_idx_q;
          mem_wdata_o     = {ADDR_W'(at_q), rd_len};
          at_d            = at_q + BR_W'(rd_len);
        end
        if (scan_end && !rd_vld_q) begin
          end_d   = at_q;
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_ctl_o.wr_en                 = 1'b1;
        mem_waddr_o                     = cursor_q[IDX_W-1:0];
        mem_wdata_o                     = {ADDR_W'(end_q), size_q};
        live_d[cursor_q[IDX_W-1:0]]     = 1'b1;
        cursor_d                        = cursor_q + 1'b1;
        live_cnt_d                      = live_cnt_q + 1'b1;
        br_d                            = br_q - BR_W'(size_q);
        end_d                           = end_q + BR_W'(size_q);
        res_status_d                    = ST_OK;
        res_grant_d                     = OFFSET_W'(end_q);
        state_d                         = S_DONE;
      end
      S_FREE: begin
        if (rd_vld_q && (CMP_W'(rd_start) == CMP_W'(off_q))) begin
          live_d[rd_idx_q] = 1'b0;
          br_d             = br_q + BR_W'(rd_len);
          if (live_cnt_q != '0) begin
            live_cnt_d = live_cnt_q - 1'b1;
          end
          res_status_d = ST_OK;
          rd_vld_d     = 1'b0;
          state_d      = S_DONE;
        end else if (scan_end && !rd_vld_q) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_grant_d  = res_grant_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      live_q      <= '0;
      live_cnt_q  <= '0;
      cursor_q    <= '0;
      br_q        <= BR_W'(POOL_BYTES);
      end_q       <= '0;
      scan_q      <= '0;
      dst_q       <= '0;
      at_q        <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      live_cnt_q  <= live_cnt_d;
      cursor_q    <= cursor_d;
      br_q        <= br_d;
      end_q       <= end_d;
      scan_q      <= scan_d;
      dst_q       <= dst_d;
      at_q        <= at_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    size_q       <= size_d;
    off_q        <= off_d;
    rd_idx_q     <= rd_idx_d;
    rd_dst_q     <= rd_dst_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    out_status_q <= out_status_d;
    out_grant_q  <= out_grant_d;
  end

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q == CNT_W'($countones(live_q)))
    else $error("live count out of step with live flags");

  a_live_below_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_cnt_q <= cursor_q) && (cursor_q <= CNT_W'(MAX_RECORDS)))
    else $error("record cursor inconsistent");

  a_end_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(end_q) <= SUM_W'(POOL_BYTES))
    else $error("end offset beyond pool");

  a_bytes_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(end_q) + SUM_W'(br_q) >= SUM_W'(POOL_BYTES))
    else $error("byte accounting lost bytes");

  a_place_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLACE) |-> !live_q[cursor_q[IDX_W-1:0]])
    else $error("placing over a live record");

endmodule
